// ----- rtl/iatv_pkg.sv -----
// ----------------------------------------------------------------------------
// iatv_pkg: shared constants for the IP address text validator
// Character codes, length bounds, saturation limits, verdict codes and digit tests.
// ----------------------------------------------------------------------------
package iatv_pkg;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Length counter
  localparam logic [5:0] LEN_SAT    = 6'd40;
  localparam logic [5:0] V4_LEN_MIN = 6'd7;
  localparam logic [5:0] V4_LEN_MAX = 6'd15;
  localparam logic [5:0] V6_LEN_MIN = 6'd15;
  localparam logic [5:0] V6_LEN_MAX = 6'd39;

  // IPv4 field tracking
  localparam logic [8:0] V4_FIELD_MAX = 9'd255;
  localparam logic [8:0] V4_FIELD_SAT = 9'd256;
  localparam logic [2:0] V4_DOTS      = 3'd3;
  localparam logic [2:0] V4_DOTS_SAT  = 3'd4;

  // IPv6 group tracking
  localparam logic [3:0] V6_COLONS     = 4'd7;
  localparam logic [3:0] V6_COLONS_SAT = 4'd8;
  localparam logic [2:0] V6_GROUP_MAX  = 3'd4;
  localparam logic [2:0] V6_GROUP_SAT  = 3'd5;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_V4   = 2'd1;
  localparam logic [1:0] VERDICT_V6   = 2'd2;

  // Decimal digit test
  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  // Hex digit test, either case
  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

endpackage

// ----- rtl/ip_address_text_validator.sv -----
// ----------------------------------------------------------------------------
// ip_address_text_validator: IPv4 / IPv6 address string checker
// Streams one character per word and returns one verdict per string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (char_valid/char_ready): one character per word in
//   char_code, with last_char set on the final character of the string.
//   Output channel (verdict_valid/verdict_ready): one word per string,
//   verdict = 0 neither, 1 valid IPv4, 2 valid IPv6.
//   A character is registered in the input register on acceptance and
//   processed from there; the verdict is registered from the updated state,
//   so the last character passes the input and verdict registers in turn.
//   Throughput is one character per cycle but for the wait below; the
//   string counters and flags update per character. Characters that are not last
//   never wait on the output side; a last character waits in the input
//   register only while an earlier verdict is still held and not taken.
//   Reset clears all string state and empties both registers. After each
//   verdict the string state returns to its reset values, so the next
//   string may follow immediately.
// ----------------------------------------------------------------------------
module ip_address_text_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       verdict_valid,
  input  logic       verdict_ready,
  output logic [1:0] verdict
);
  import iatv_pkg::*;

  // Input register
  logic       in_full;
  logic [7:0] in_char;
  logic       in_last;

  // String state
  logic [5:0] char_count;
  logic       seen_dot;
  logic       v4_failed;
  logic [2:0] v4_dots;
  logic [8:0] v4_field_value;
  logic       v4_field_empty;
  logic       v4_field_zero_lead;
  logic       v6_failed;
  logic [2:0] v6_group_digits;
  logic [3:0] v6_colons;

  // Next-state values
  logic [5:0]  char_count_next;
  logic        seen_dot_next;
  logic        v4_failed_next;
  logic [2:0]  v4_dots_next;
  logic [8:0]  v4_field_value_next;
  logic        v4_field_empty_next;
  logic        v4_field_zero_lead_next;
  logic        v6_failed_next;
  logic [2:0]  v6_group_digits_next;
  logic [3:0]  v6_colons_next;
  logic [11:0] v4_acc;
  logic [1:0]  verdict_next;

  logic fire;

  // Process the held character unless it is last and the verdict slot is busy
  assign fire       = in_full && (!in_last || !verdict_valid || verdict_ready);
  assign char_ready = !in_full || fire;

  // Per-character update of both forms
  always_comb begin
    v4_acc = 12'(v4_field_value) * 12'd10 + 12'(in_char - CH_ZERO);

    char_count_next         = (char_count < LEN_SAT) ? char_count + 6'd1 : char_count;
    seen_dot_next           = seen_dot;
    v4_failed_next          = v4_failed;
    v4_dots_next            = v4_dots;
    v4_field_value_next     = v4_field_value;
    v4_field_empty_next     = v4_field_empty;
    v4_field_zero_lead_next = v4_field_zero_lead;
    v6_failed_next          = v6_failed;
    v6_group_digits_next    = v6_group_digits;
    v6_colons_next          = v6_colons;

    // IPv4 dotted decimal
    if (in_char == CH_DOT) begin
      seen_dot_next = 1'b1;
      if (v4_field_empty || v4_field_value > V4_FIELD_MAX || v4_dots >= V4_DOTS) begin
        v4_failed_next = 1'b1;
      end
      if (v4_dots < V4_DOTS_SAT) begin
        v4_dots_next = v4_dots + 3'd1;
      end
      v4_field_value_next     = '0;
      v4_field_empty_next     = 1'b1;
      v4_field_zero_lead_next = 1'b0;
    end else if (is_dec(in_char)) begin
      if (v4_field_zero_lead) begin
        v4_failed_next = 1'b1;
      end
      if (v4_field_empty && in_char == CH_ZERO) begin
        v4_field_zero_lead_next = 1'b1;
      end
      v4_field_value_next = (v4_acc > 12'(V4_FIELD_SAT)) ? V4_FIELD_SAT : v4_acc[8:0];
      v4_field_empty_next = 1'b0;
    end else begin
      v4_failed_next = 1'b1;
    end

    // IPv6 colon hex
    if (in_char == CH_COLON) begin
      if (v6_group_digits == 3'd0 || v6_colons >= V6_COLONS) begin
        v6_failed_next = 1'b1;
      end
      if (v6_colons < V6_COLONS_SAT) begin
        v6_colons_next = v6_colons + 4'd1;
      end
      v6_group_digits_next = '0;
    end else if (is_hex(in_char)) begin
      if (v6_group_digits >= V6_GROUP_MAX) begin
        v6_failed_next = 1'b1;
      end
      if (v6_group_digits < V6_GROUP_SAT) begin
        v6_group_digits_next = v6_group_digits + 3'd1;
      end
    end else begin
      v6_failed_next = 1'b1;
    end

    // Final judgement on the updated state
    verdict_next = VERDICT_NONE;
    if (seen_dot_next) begin
      if (!v4_failed_next && v4_dots_next == V4_DOTS && !v4_field_empty_next &&
          v4_field_value_next <= V4_FIELD_MAX &&
          char_count_next >= V4_LEN_MIN && char_count_next <= V4_LEN_MAX) begin
        verdict_next = VERDICT_V4;
      end
    end else begin
      if (!v6_failed_next && v6_colons_next == V6_COLONS && v6_group_digits_next != 3'd0 &&
          char_count_next >= V6_LEN_MIN && char_count_next <= V6_LEN_MAX) begin
        verdict_next = VERDICT_V6;
      end
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_ready) begin
      in_full <= char_valid;
    end
    if (char_ready && char_valid) begin
      in_char <= char_code;
      in_last <= last_char;
    end
  end

  // String state: updated per character, cleared after the last one
  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      char_count         <= '0;
      seen_dot           <= 1'b0;
      v4_failed          <= 1'b0;
      v4_dots            <= '0;
      v4_field_value     <= '0;
      v4_field_empty     <= 1'b1;
      v4_field_zero_lead <= 1'b0;
      v6_failed          <= 1'b0;
      v6_group_digits    <= '0;
      v6_colons          <= '0;
    end else if (fire) begin
      char_count         <= char_count_next;
      seen_dot           <= seen_dot_next;
      v4_failed          <= v4_failed_next;
      v4_dots            <= v4_dots_next;
      v4_field_value     <= v4_field_value_next;
      v4_field_empty     <= v4_field_empty_next;
      v4_field_zero_lead <= v4_field_zero_lead_next;
      v6_failed          <= v6_failed_next;
      v6_group_digits    <= v6_group_digits_next;
      v6_colons          <= v6_colons_next;
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (fire && in_last) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
    if (fire && in_last) begin
      verdict <= verdict_next;
    end
  end

endmodule

// ----- tb/ip_address_text_validator_tb.sv -----
// ----------------------------------------------------------------------------
// ip_address_text_validator_tb: self-checking bench for the address validator
// Streams address strings one character per word, predicts the verdict of
// each string with an independent behavioral tracker, and checks every
// verdict word in order. Covers directed corner strings, random well-formed
// IPv4/IPv6 text with mutations and noise, several idle/stall mixes, a long
// output hold-off that backs up the input, and a drain-between-strings pass.
// ----------------------------------------------------------------------------
module ip_address_text_validator_tb;
  import iatv_pkg::*;

  localparam int RUN_LIMIT = 200000;  // cycles before giving up
  localparam int LONG_HOLD = 300;     // output hold-off length in cycles
  localparam int TAIL_WAIT = 20;      // settle time after the last verdict

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       verdict_valid;
  logic       verdict_ready = 1'b0;
  logic [1:0] verdict;

  ip_address_text_validator dut (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .char_code     (char_code),
    .last_char     (last_char),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

  // Clock: period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle and stall mix, in percent
  int gap_pct   = 0;
  int stall_pct = 0;

  // Long output hold-off, counted by the ready process
  logic hold_on   = 1'b0;
  int   held_cnt  = 0;

  int cycle_cnt    = 0;
  int mismatch_cnt = 0;
  int sent_chars   = 0;

  // Verdicts still owed by the block, oldest first
  logic [1:0] pending_verdicts[$];

  // Text of the string being built
  logic [7:0] text_buf[$];
  string      hex_chars = "0123456789abcdefABCDEF";

  // Per-string tracking state
  logic [5:0] len_cnt;
  logic       dot_seen;
  logic       v4_bad;
  logic [2:0] dot_cnt;
  logic [8:0] field_val;
  logic       field_empty;
  logic       field_zero;
  logic       v6_bad;
  logic [2:0] grp_digits;
  logic [3:0] colon_cnt;

  function automatic logic is_decimal(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  task automatic clear_tracking();
    len_cnt     = '0;
    dot_seen    = 1'b0;
    v4_bad      = 1'b0;
    dot_cnt     = '0;
    field_val   = '0;
    field_empty = 1'b1;
    field_zero  = 1'b0;
    v6_bad      = 1'b0;
    grp_digits  = '0;
    colon_cnt   = '0;
  endtask

  // Advance the tracker by one accepted character; queue a verdict on last
  task automatic track_char(input logic [7:0] c, input logic last);
    int         acc;
    logic [1:0] vd;
    if (len_cnt < LEN_SAT) len_cnt++;

    // dotted decimal form
    if (c == CH_DOT) begin
      dot_seen = 1'b1;
      if (field_empty || field_val > V4_FIELD_MAX || dot_cnt >= V4_DOTS) v4_bad = 1'b1;
      if (dot_cnt < V4_DOTS_SAT) dot_cnt++;
      field_val   = '0;
      field_empty = 1'b1;
      field_zero  = 1'b0;
    end else if (is_decimal(c)) begin
      if (field_zero) v4_bad = 1'b1;
      if (field_empty && c == CH_ZERO) field_zero = 1'b1;
      acc = int'(field_val) * 10 + int'(c) - int'(CH_ZERO);
      field_val   = (acc > int'(V4_FIELD_SAT)) ? V4_FIELD_SAT : acc[8:0];
      field_empty = 1'b0;
    end else begin
      v4_bad = 1'b1;
    end

    // colon-separated hex form
    if (c == CH_COLON) begin
      if (grp_digits == 0 || colon_cnt >= V6_COLONS) v6_bad = 1'b1;
      if (colon_cnt < V6_COLONS_SAT) colon_cnt++;
      grp_digits = '0;
    end else if (is_decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      if (grp_digits >= V6_GROUP_MAX) v6_bad = 1'b1;
      if (grp_digits < V6_GROUP_SAT) grp_digits++;
    end else begin
      v6_bad = 1'b1;
    end

    if (last) begin
      vd = VERDICT_NONE;
      if (dot_seen) begin
        if (!v4_bad && dot_cnt == V4_DOTS && !field_empty && field_val <= V4_FIELD_MAX &&
            len_cnt >= V4_LEN_MIN && len_cnt <= V4_LEN_MAX) vd = VERDICT_V4;
      end else begin
        if (!v6_bad && colon_cnt == V6_COLONS && grp_digits != 0 &&
            len_cnt >= V6_LEN_MIN && len_cnt <= V6_LEN_MAX) vd = VERDICT_V6;
      end
      pending_verdicts.push_back(vd);
      clear_tracking();
    end
  endtask

  // Watch both channels: predict on accepted characters, check verdict words
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && char_ready) track_char(char_code, last_char);
      if (verdict_valid && verdict_ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: verdict %0d with none expected", $time, verdict);
          mismatch_cnt++;
        end else begin
          if (verdict !== pending_verdicts[0]) begin
            $display("%0t: verdict mismatch, expected %0d, got %0d",
                     $time, pending_verdicts[0], verdict);
            mismatch_cnt++;
          end
          void'(pending_verdicts.pop_front());
        end
      end
    end
  end

  // Output side ready, with random stalls or a counted long hold-off
  always @(posedge clk) begin
    if (hold_on) begin
      verdict_ready <= 1'b0;
      held_cnt      <= held_cnt + 1;
    end else begin
      verdict_ready <= ($urandom_range(99) >= stall_pct);
      held_cnt      <= 0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one character word and wait until it is taken
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    last_char  <= last;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    sent_chars++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Stop offering and wait for every owed verdict
  task automatic drain_verdicts();
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_dec(input int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Dotted decimal text; fields lean toward the interesting values
  task automatic make_v4();
    int k;
    text_buf.delete();
    for (int f = 0; f < 4; f++) begin
      if (f != 0) text_buf.push_back(CH_DOT);
      k = $urandom_range(19);
      if (k < 4)       put_dec($urandom_range(9));
      else if (k < 8)  put_dec($urandom_range(99, 10));
      else if (k < 12) put_dec($urandom_range(255, 100));
      else if (k < 15) put_dec($urandom_range(255, 250));
      else if (k < 17) put_dec($urandom_range(999, 256));
      else if (k == 17) begin
        text_buf.push_back(CH_ZERO);
        put_dec($urandom_range(99));
      end else if (k == 19) begin
        put_dec(0);
      end
      // k == 18 leaves the field empty
    end
  endtask

  // Colon-separated hex text, mixed case, mostly eight groups of 1 to 4
  task automatic make_v6();
    int groups;
    int n;
    text_buf.delete();
    groups = ($urandom_range(99) < 90) ? 8 : $urandom_range(9, 6);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text_buf.push_back(CH_COLON);
      n = ($urandom_range(99) < 94) ? $urandom_range(4, 1) : $urandom_range(1) * 5;
      repeat (n) text_buf.push_back(hex_chars[$urandom_range(21)]);
    end
    if (text_buf.size() == 0) text_buf.push_back(CH_COLON);
  endtask

  // Break a string in one place
  task automatic mutate_text();
    int pos;
    pos = $urandom_range(text_buf.size() - 1);
    case ($urandom_range(4))
      0: text_buf[pos] = 8'($urandom_range(255));
      1: text_buf[pos] = $urandom_range(1) ? CH_DOT : CH_COLON;
      2: if (text_buf.size() > 1) text_buf.delete(pos);
      3: text_buf.insert(pos, 8'($urandom_range(126, 32)));
      default: text_buf.insert(pos, text_buf[pos]);
    endcase
  endtask

  task automatic make_noise();
    int n;
    text_buf.delete();
    n = $urandom_range(45, 1);
    repeat (n) begin
      if ($urandom_range(1)) text_buf.push_back(hex_chars[$urandom_range(21)]);
      else if ($urandom_range(3) == 0) text_buf.push_back($urandom_range(1) ? CH_DOT : CH_COLON);
      else text_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    int r;
    start = sent_chars;
    while (sent_chars - start < budget) begin
      r = $urandom_range(99);
      if (r < 35) make_v4();
      else if (r < 70) make_v6();
      else if (r < 88) begin
        if ($urandom_range(1)) make_v4();
        else make_v6();
        mutate_text();
      end else make_noise();
      send_text();
    end
    drain_verdicts();
  endtask

  // Corner strings of both forms
  task automatic test_directed();
    string cases[$];
    cases = '{"0.0.0.0", "255.255.255.255", "256.1.1.1", "99999.1.1.1", ".1.2.3",
              "1.2.3.", "1..2.3", "01.2.3.4", "1.2.3.4.5", "1.2.3.4:5",
              "0:0:0:0:0:0:0:0", "ffff:FFFF:abcd:ABCD:0123:4567:89ab:cdef",
              "1:2:3:4:5:6:7:12345", "1:2:3:4:5:6:7", "1:2:3:4:5:6:7:8:9",
              "::1:2:3:4:5:6:7", "g:2:3:4:5:6:7:8", "7"};
    foreach (cases[i]) begin
      load_text(cases[i]);
      send_text();
    end
    // codes outside ASCII, zero byte, and an over-long string
    load_text("10.0.0.1");
    text_buf[2] = 8'h80;
    send_text();
    load_text("0:0:0:0:0:0:0:0");
    text_buf[4] = 8'h00;
    send_text();
    load_text("");
    text_buf.push_back(8'hFF);
    send_text();
    load_text("");
    repeat (45) text_buf.push_back("a");
    send_text();
    drain_verdicts();
  endtask

  task automatic test_streaming();
    gap_pct   = 0;
    stall_pct = 0;
    run_random(70);
  endtask

  task automatic test_sender_gaps();
    gap_pct   = 46;
    stall_pct = 0;
    run_random(70);
  endtask

  task automatic test_receiver_stalls();
    gap_pct   = 0;
    stall_pct = 46;
    run_random(70);
  endtask

  task automatic test_light_idle();
    gap_pct   = 6;
    stall_pct = 6;
    run_random(70);
  endtask

  // Hold the output off long enough for the input to back up
  task automatic test_output_hold();
    gap_pct   = 0;
    stall_pct = 0;
    hold_on <= 1'b1;
    fork
      begin
        repeat (12) begin
          make_v4();
          send_text();
        end
        char_valid <= 1'b0;
      end
      begin
        @(posedge clk);
        while (held_cnt < LONG_HOLD) @(posedge clk);
        hold_on <= 1'b0;
      end
    join
    drain_verdicts();
  endtask

  // One string at a time, waiting for each verdict before the next
  task automatic test_drain_between();
    gap_pct   = 6;
    stall_pct = 6;
    repeat (8) begin
      if ($urandom_range(1)) make_v4();
      else make_v6();
      send_text();
      drain_verdicts();
    end
  endtask

  initial begin
    clear_tracking();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_light_idle();
    test_output_hold();
    test_drain_between();

    drain_verdicts();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
